// ===== design/gbs_pkg.sv =====
// ----------------------------------------------------------------------------
// gbs_pkg
// shared sizes for the gini best split search block
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int CLASSES     = 16;

  localparam int VAL_W  = 32;
  localparam int CLS_W  = 4;
  localparam int ENT_W  = VAL_W + CLS_W;
  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int CIDX_W = (CLASSES > 1) ? $clog2(CLASSES) : 1;
  localparam int SQ_W   = 2 * CNT_W;
  localparam int FRAC   = 31;
  localparam int NUM_W  = SQ_W + FRAC;
  localparam int IMP_W  = 32;
  localparam int GS_W   = IMP_W + 1;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  localparam logic [VAL_W-1:0] SIGN_BIAS = {1'b1, {(VAL_W-1){1'b0}}};
  localparam int               Q_ONE     = 65536;

endpackage

// ===== design/gbs_div.sv =====
// ----------------------------------------------------------------------------
// gbs_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gbs_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [gbs_pkg::NUM_W-1:0] num,
  input  logic [gbs_pkg::SQ_W-1:0]  den,
  output logic                      done,
  output logic [gbs_pkg::NUM_W-1:0] quo
);

  logic [gbs_pkg::SQ_W-1:0]   rem_r, rem_nxt;
  logic [gbs_pkg::NUM_W-1:0]  quo_r, quo_nxt;
  logic [gbs_pkg::SQ_W-1:0]   den_r, den_nxt;
  logic [gbs_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [gbs_pkg::SQ_W:0]     trial;
  logic [gbs_pkg::SQ_W:0]     diff;

  always_comb begin
    trial    = {rem_r, quo_r[gbs_pkg::NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
      cnt_nxt  = gbs_pkg::DCNT_W'(gbs_pkg::NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[gbs_pkg::SQ_W]) begin
        rem_nxt = diff[gbs_pkg::SQ_W-1:0];
        quo_nxt = {quo_r[gbs_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[gbs_pkg::SQ_W-1:0];
        quo_nxt = {quo_r[gbs_pkg::NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == gbs_pkg::DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== design/gini_best_split_search.sv =====
// ----------------------------------------------------------------------------
// gini_best_split_search
// best gini split threshold over the samples of one feature
// ----------------------------------------------------------------------------
// samples enter on the in_ stream, one transaction per cycle while loading;
// in_tuser marks a sample that carries a value, in_tlast ends the set.
// after the last sample the block drops in_tready and searches: it sorts the
// valued samples in place (insertion sort, one shift per cycle on the sample
// memory), then scans them in order through its read, check and update states.
// the gini terms come from one shared serial divider, and the search runs one
// term for the no-value samples, one for the start point and two at every
// boundary between distinct values.
// the result is one transaction on the out_ stream; it is held while
// out_tready is low, and loading of the next set starts once it is taken.
// rst_n (synchronous) clears all counts and returns to loading.
// ----------------------------------------------------------------------------
module gini_best_split_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // feature_value, class_label, zero fill
  input  logic        in_tuser,   // has_value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // best_impurity, best_threshold
);

  typedef enum logic [13:0] {
    ST_LOAD  = 14'b00000000000001,
    ST_NV    = 14'b00000000000010,
    ST_TMUL  = 14'b00000000000100,
    ST_TGO   = 14'b00000000001000,
    ST_TWAIT = 14'b00000000010000,
    ST_SOI   = 14'b00000000100000,
    ST_SOKEY = 14'b00000001000000,
    ST_SOCMP = 14'b00000010000000,
    ST_SOPUT = 14'b00000100000000,
    ST_SCRD  = 14'b00001000000000,
    ST_SCCHK = 14'b00010000000000,
    ST_SCUPD = 14'b00100000000000,
    ST_OUT   = 14'b01000000000000,
    ST_SPARE = 14'b10000000000000
  } state_t;

  typedef enum logic [1:0] {
    RET_NV, RET_BASE, RET_LO, RET_UP
  } ret_t;

  localparam int CW = gbs_pkg::CNT_W;
  localparam int QW = gbs_pkg::SQ_W;

  state_t state_r, state_nxt;
  ret_t   ret_r, ret_nxt;

  logic [CW-1:0] up_r   [gbs_pkg::CLASSES];
  logic [CW-1:0] up_nxt [gbs_pkg::CLASSES];
  logic [CW-1:0] lo_r   [gbs_pkg::CLASSES];
  logic [CW-1:0] lo_nxt [gbs_pkg::CLASSES];
  logic [CW-1:0] ms_r   [gbs_pkg::CLASSES];
  logic [CW-1:0] ms_nxt [gbs_pkg::CLASSES];

  logic [QW-1:0] sq_up_r, sq_up_nxt, sq_lo_r, sq_lo_nxt, sq_ms_r, sq_ms_nxt;
  logic [CW-1:0] n_r, n_nxt, v_r, v_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, idx_r, idx_nxt;
  logic [CW-1:0] up_n_r, up_n_nxt, lo_n_r, lo_n_nxt;
  logic [CW-1:0] ts_s_r, ts_s_nxt;
  logic [QW-1:0] ts_sq_r, ts_sq_nxt, s2_r, s2_nxt, sn_r, sn_nxt;
  logic [gbs_pkg::VAL_W-1:0] key_r, key_nxt;
  logic [gbs_pkg::CLS_W-1:0] kcls_r, kcls_nxt;
  logic signed [31:0] prev_r, prev_nxt, next_r, next_nxt, thr_r, thr_nxt;
  logic [gbs_pkg::GS_W-1:0] best_r, best_nxt, gnv_r, gnv_nxt, glo_r, glo_nxt;
  logic [gbs_pkg::IMP_W-1:0] oimp_r, oimp_nxt;

  logic [gbs_pkg::ENT_W-1:0] mem [gbs_pkg::MAX_SAMPLES];
  logic [gbs_pkg::ENT_W-1:0] rd_r;
  logic                      mem_we, mem_re;
  logic [gbs_pkg::ADDR_W-1:0] mem_wa, mem_ra;
  logic [gbs_pkg::ENT_W-1:0] mem_wd;

  logic                      div_start, div_done;
  logic [gbs_pkg::NUM_W-1:0] div_num, div_quo;
  logic [QW-1:0]             div_den;
  logic [gbs_pkg::GS_W-1:0]  q;

  logic [gbs_pkg::VAL_W-1:0] in_val;
  logic [gbs_pkg::CLS_W-1:0] in_cls;
  logic [gbs_pkg::CIDX_W-1:0] ci;
  logic                      acc;
  logic signed [32:0]        t33, m33;
  logic signed [31:0]        rd_val;
  logic [gbs_pkg::GS_W-1:0]  gini;
  logic [CW-1:0]             cu, cl;

  gbs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_val = in_tdata[gbs_pkg::VAL_W-1:0];
  assign in_cls = in_tdata[gbs_pkg::ENT_W-1:gbs_pkg::VAL_W];
  assign acc    = in_tvalid && in_tready;
  assign rd_val = signed'(rd_r[gbs_pkg::VAL_W-1:0] ^ gbs_pkg::SIGN_BIAS);
  assign q      = gbs_pkg::GS_W'(div_quo[gbs_pkg::IMP_W-1:0]);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    up_nxt    = up_r;
    lo_nxt    = lo_r;
    ms_nxt    = ms_r;
    sq_up_nxt = sq_up_r;
    sq_lo_nxt = sq_lo_r;
    sq_ms_nxt = sq_ms_r;
    n_nxt     = n_r;
    v_nxt     = v_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    idx_nxt   = idx_r;
    up_n_nxt  = up_n_r;
    lo_n_nxt  = lo_n_r;
    ts_s_nxt  = ts_s_r;
    ts_sq_nxt = ts_sq_r;
    s2_nxt    = s2_r;
    sn_nxt    = sn_r;
    key_nxt   = key_r;
    kcls_nxt  = kcls_r;
    prev_nxt  = prev_r;
    next_nxt  = next_r;
    thr_nxt   = thr_r;
    best_nxt  = best_r;
    gnv_nxt   = gnv_r;
    glo_nxt   = glo_r;
    oimp_nxt  = oimp_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wa    = '0;
    mem_ra    = '0;
    mem_wd    = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    ci        = '0;
    cu        = '0;
    cl        = '0;
    t33       = '0;
    m33       = '0;
    gini      = '0;

    unique case (state_r)
      ST_LOAD: begin
        ci = gbs_pkg::CIDX_W'(in_cls);
        if (acc) begin
          if (32'(n_r) < gbs_pkg::MAX_SAMPLES && 32'(in_cls) < gbs_pkg::CLASSES) begin
            if (in_tuser) begin
              mem_we     = 1'b1;
              mem_wa     = v_r[gbs_pkg::ADDR_W-1:0];
              mem_wd     = {in_cls, in_val ^ gbs_pkg::SIGN_BIAS};
              up_nxt[ci] = up_r[ci] + 1'b1;
              sq_up_nxt  = sq_up_r + QW'({up_r[ci], 1'b1});
              v_nxt      = v_r + 1'b1;
            end else begin
              ms_nxt[ci] = ms_r[ci] + 1'b1;
              sq_ms_nxt  = sq_ms_r + QW'({ms_r[ci], 1'b1});
            end
            n_nxt = n_r + 1'b1;
          end
          if (in_tlast) begin
            state_nxt = ST_NV;
          end
        end
      end
      ST_NV: begin
        ts_s_nxt  = n_r - v_r;
        ts_sq_nxt = sq_ms_r;
        ret_nxt   = RET_NV;
        state_nxt = ST_TMUL;
      end
      ST_TMUL: begin
        s2_nxt    = QW'(ts_s_r) * QW'(ts_s_r);
        sn_nxt    = QW'(ts_s_r) * QW'(n_r);
        state_nxt = ST_TGO;
      end
      ST_TGO: begin
        div_start = 1'b1;
        if (ts_s_r == '0 || n_r == '0) begin
          div_num = '0;
          div_den = QW'(1);
        end else begin
          div_num = gbs_pkg::NUM_W'(s2_r - ts_sq_r) << gbs_pkg::FRAC;
          div_den = sn_r;
        end
        state_nxt = ST_TWAIT;
      end
      ST_TWAIT: begin
        if (div_done) begin
          unique case (ret_r)
            RET_NV: begin
              gnv_nxt = q;
              if (v_r == '0) begin
                oimp_nxt  = q[gbs_pkg::IMP_W-1:0];
                thr_nxt   = '0;
                state_nxt = ST_OUT;
              end else begin
                i_nxt     = CW'(1);
                state_nxt = ST_SOI;
              end
            end
            RET_BASE: begin
              best_nxt  = q;
              idx_nxt   = '0;
              up_n_nxt  = v_r;
              lo_n_nxt  = '0;
              state_nxt = ST_SCRD;
            end
            RET_LO: begin
              glo_nxt   = q;
              ts_s_nxt  = up_n_r;
              ts_sq_nxt = sq_up_r;
              ret_nxt   = RET_UP;
              state_nxt = ST_TMUL;
            end
            RET_UP: begin
              gini = glo_r + q;
              if (gini < best_r) begin
                best_nxt = gini;
                m33      = 33'(prev_r) + 33'(next_r);
                thr_nxt  = m33[32:1];
              end
              state_nxt = ST_SCUPD;
            end
            default: state_nxt = ST_SCUPD;
          endcase
        end
      end
      ST_SOI: begin
        if (i_r == v_r) begin
          ts_s_nxt  = v_r;
          ts_sq_nxt = sq_up_r;
          ret_nxt   = RET_BASE;
          state_nxt = ST_TMUL;
        end else begin
          mem_re    = 1'b1;
          mem_ra    = i_r[gbs_pkg::ADDR_W-1:0];
          state_nxt = ST_SOKEY;
        end
      end
      ST_SOKEY: begin
        key_nxt   = rd_r[gbs_pkg::VAL_W-1:0];
        kcls_nxt  = rd_r[gbs_pkg::ENT_W-1:gbs_pkg::VAL_W];
        j_nxt     = i_r;
        mem_re    = 1'b1;
        mem_ra    = gbs_pkg::ADDR_W'(i_r - 1'b1);
        state_nxt = ST_SOCMP;
      end
      ST_SOCMP: begin
        mem_we = 1'b1;
        mem_wa = j_r[gbs_pkg::ADDR_W-1:0];
        if (rd_r[gbs_pkg::VAL_W-1:0] > key_r) begin
          mem_wd = rd_r;
          j_nxt  = j_r - 1'b1;
          if (j_r == CW'(1)) begin
            state_nxt = ST_SOPUT;
          end else begin
            mem_re = 1'b1;
            mem_ra = gbs_pkg::ADDR_W'(j_r - CW'(2));
          end
        end else begin
          mem_wd    = {kcls_r, key_r};
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_SOI;
        end
      end
      ST_SOPUT: begin
        mem_we    = 1'b1;
        mem_wa    = '0;
        mem_wd    = {kcls_r, key_r};
        i_nxt     = i_r + 1'b1;
        state_nxt = ST_SOI;
      end
      ST_SCRD: begin
        if (idx_r == v_r) begin
          gini      = best_r + gnv_r;
          oimp_nxt  = gini[gbs_pkg::IMP_W-1:0];
          state_nxt = ST_OUT;
        end else begin
          mem_re    = 1'b1;
          mem_ra    = idx_r[gbs_pkg::ADDR_W-1:0];
          state_nxt = ST_SCCHK;
        end
      end
      ST_SCCHK: begin
        if (idx_r == '0) begin
          t33 = 33'(rd_val) - 33'(gbs_pkg::Q_ONE);
          if (t33[32] != t33[31]) begin
            thr_nxt = {1'b1, 31'b0};
          end else begin
            thr_nxt = t33[31:0];
          end
          state_nxt = ST_SCUPD;
        end else if (rd_val != prev_r) begin
          next_nxt  = rd_val;
          ts_s_nxt  = lo_n_r;
          ts_sq_nxt = sq_lo_r;
          ret_nxt   = RET_LO;
          state_nxt = ST_TMUL;
        end else begin
          state_nxt = ST_SCUPD;
        end
      end
      ST_SCUPD: begin
        ci         = gbs_pkg::CIDX_W'(rd_r[gbs_pkg::ENT_W-1:gbs_pkg::VAL_W]);
        cu         = up_r[ci];
        cl         = lo_r[ci];
        up_nxt[ci] = cu - 1'b1;
        lo_nxt[ci] = cl + 1'b1;
        sq_up_nxt  = sq_up_r - (QW'({cu, 1'b0}) - QW'(1));
        sq_lo_nxt  = sq_lo_r + QW'({cl, 1'b1});
        up_n_nxt   = up_n_r - 1'b1;
        lo_n_nxt   = lo_n_r + 1'b1;
        prev_nxt   = rd_val;
        idx_nxt    = idx_r + 1'b1;
        state_nxt  = ST_SCRD;
      end
      ST_OUT: begin
        if (out_tready) begin
          for (int k = 0; k < gbs_pkg::CLASSES; k++) begin
            up_nxt[k] = '0;
            lo_nxt[k] = '0;
            ms_nxt[k] = '0;
          end
          sq_up_nxt = '0;
          sq_lo_nxt = '0;
          sq_ms_nxt = '0;
          n_nxt     = '0;
          v_nxt     = '0;
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      ret_r   <= RET_NV;
      for (int k = 0; k < gbs_pkg::CLASSES; k++) begin
        up_r[k] <= '0;
        lo_r[k] <= '0;
        ms_r[k] <= '0;
      end
      sq_up_r <= '0;
      sq_lo_r <= '0;
      sq_ms_r <= '0;
      n_r     <= '0;
      v_r     <= '0;
      i_r     <= '0;
      j_r     <= '0;
      idx_r   <= '0;
      up_n_r  <= '0;
      lo_n_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      up_r    <= up_nxt;
      lo_r    <= lo_nxt;
      ms_r    <= ms_nxt;
      sq_up_r <= sq_up_nxt;
      sq_lo_r <= sq_lo_nxt;
      sq_ms_r <= sq_ms_nxt;
      n_r     <= n_nxt;
      v_r     <= v_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      idx_r   <= idx_nxt;
      up_n_r  <= up_n_nxt;
      lo_n_r  <= lo_n_nxt;
    end
    ts_s_r  <= ts_s_nxt;
    ts_sq_r <= ts_sq_nxt;
    s2_r    <= s2_nxt;
    sn_r    <= sn_nxt;
    key_r   <= key_nxt;
    kcls_r  <= kcls_nxt;
    prev_r  <= prev_nxt;
    next_r  <= next_nxt;
    thr_r   <= thr_nxt;
    best_r  <= best_nxt;
    gnv_r   <= gnv_nxt;
    glo_r   <= glo_nxt;
    oimp_r  <= oimp_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_r <= mem[mem_ra];
    end
  end

  assign in_tready  = (state_r == ST_LOAD);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {thr_r, oimp_r};

endmodule
